@@ design/etf_pkg.sv @@
package etf_pkg;

    // fixed field widths
    localparam int PIX_W      = 6;
    localparam int PIX_COUNT  = 1 << PIX_W;
    localparam int Q_W        = 32;
    localparam int PROD_W     = 2 * Q_W;
    localparam int CJ_W       = 26;
    localparam int BAIL_W     = 29;
    localparam int ITER_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;
    localparam int SUM_W      = 42;

    localparam int GRID_SIZE_DEF = 64;

    // register reset values
    localparam logic [BAIL_W-1:0] BAILOUT_RST  = BAIL_W'(67108864);
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JULIA_MODE,
        CFG_C_REAL,
        CFG_C_IMAG,
        CFG_BAILOUT,
        CFG_MAX_ITER
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_UPDATE,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        OP_RR,
        OP_II,
        OP_RI
    } op_sel_t;

    typedef struct packed {
        logic    load;
        op_sel_t op_sel;
        logic    cap_rr;
        logic    cap_diff;
        logic    update;
        logic    in_ready;
        logic    out_valid;
    } ctrl_t;

    typedef struct packed {
        logic iter_done;
        logic escaped;
    } status_t;

    typedef logic signed [Q_W-1:0] coord_tbl_t [PIX_COUNT];

    // clamp a wide signed sum into 32 bits
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[SUM_W-1:Q_W-1] == {(SUM_W-Q_W+1){v[SUM_W-1]}}) begin
            r = v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ design/etf_mul.sv @@
module etf_mul
    import etf_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [Q_W-1:0]    op_a,
    input  logic signed [Q_W-1:0]    op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ design/etf_seq.sv @@
module etf_seq
    import etf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    out_ready,
    input  status_t status,
    output ctrl_t   ctrl
);

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_MUL_RR;
            end
            ST_MUL_RR: begin
                state_next = status.iter_done ? ST_OUT : ST_MUL_II;
            end
            ST_MUL_II: begin
                state_next = ST_MUL_RI;
            end
            ST_MUL_RI: begin
                state_next = status.escaped ? ST_OUT : ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_MUL_RR;
            end
            ST_OUT: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.op_sel = OP_RR;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                ctrl.load     = in_valid;
            end
            ST_MUL_RR: begin
                ctrl.op_sel = OP_RR;
            end
            ST_MUL_II: begin
                ctrl.op_sel = OP_II;
                ctrl.cap_rr = 1'b1;
            end
            ST_MUL_RI: begin
                ctrl.op_sel   = OP_RI;
                ctrl.cap_diff = 1'b1;
            end
            ST_UPDATE: begin
                ctrl.update = 1'b1;
            end
            ST_OUT: begin
                ctrl.out_valid = 1'b1;
            end
            default: begin
                ctrl.op_sel = OP_RR;
            end
        endcase
    end

endmodule

@@ design/escape_time_fractal_pixel_core.sv @@
// channel   ports                                   beat carries
// s_        s_valid s_ready s_pixel_col s_pixel_row  one pixel of the grid
// m_        m_valid m_ready m_final_real m_final_imag final z, signed Q8.24
// cfg_      cfg_wr_en cfg_index cfg_wdata            one register write
//
// one pixel runs n steps from accept to result, n at most the configured step
// bound, and the escape test can stop it early; each step runs zr*zr, zi*zi
// and zr*zi in turn on the single shared 32x32 multiplier, then the update
// synchronous active-low reset clears the sequencer and step counter and resets the configuration registers
// s_ready is high only while idle; a stalled result holds until m_ready
module escape_time_fractal_pixel_core
    import etf_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // pixel input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic        [PIX_W-1:0]      s_pixel_col,
    input  logic        [PIX_W-1:0]      s_pixel_row,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [Q_W-1:0]        m_final_real,
    output logic signed [Q_W-1:0]        m_final_imag,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_wdata
);

    // pixel index to coordinate: (2*i - G) * 2^25 / G, rounded toward zero,
    // one constant per grid index
    coord_tbl_t map_tbl;

    for (genvar g = 0; g < PIX_COUNT; g++) begin : g_map
        localparam longint MAP_NUM =
            (2 * longint'(g) - longint'(GRID_SIZE)) * (longint'(1) <<< 25);
        localparam logic signed [Q_W-1:0] MAP_VAL = Q_W'(MAP_NUM / longint'(GRID_SIZE));
        assign map_tbl[g] = MAP_VAL;
    end

    // configuration registers
    logic                     julia_mode_reg;
    logic signed [CJ_W-1:0]   c_real_reg;
    logic signed [CJ_W-1:0]   c_imag_reg;
    logic        [BAIL_W-1:0] bailout_reg;
    logic        [ITER_W-1:0] max_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            julia_mode_reg <= 1'b0;
            c_real_reg     <= '0;
            c_imag_reg     <= '0;
            bailout_reg    <= BAILOUT_RST;
            max_iter_reg   <= MAX_ITER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_JULIA_MODE: julia_mode_reg <= cfg_wdata[0];
                CFG_C_REAL:     c_real_reg     <= cfg_wdata[CJ_W-1:0];
                CFG_C_IMAG:     c_imag_reg     <= cfg_wdata[CJ_W-1:0];
                CFG_BAILOUT:    bailout_reg    <= cfg_wdata[BAIL_W-1:0];
                CFG_MAX_ITER:   max_iter_reg   <= cfg_wdata[ITER_W-1:0];
                default: ;  // indexes beyond the register list are dropped
            endcase
        end
    end

    // sequencer
    ctrl_t   ctrl;
    status_t status;

    etf_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .out_ready (m_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // datapath state
    logic signed [Q_W-1:0]    zr_reg, zr_next;
    logic signed [Q_W-1:0]    zi_reg, zi_next;
    logic signed [Q_W-1:0]    cr_reg, cr_next;
    logic signed [Q_W-1:0]    ci_reg, ci_next;
    logic        [ITER_W-1:0] n_reg, n_next;
    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] diff_reg;

    // shared multiplier, operands picked by the sequencer
    logic signed [Q_W-1:0]    op_a;
    logic signed [Q_W-1:0]    op_b;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        unique case (ctrl.op_sel)
            OP_RR: begin
                op_a = zr_reg;
                op_b = zr_reg;
            end
            OP_II: begin
                op_a = zi_reg;
                op_b = zi_reg;
            end
            OP_RI: begin
                op_a = zr_reg;
                op_b = zi_reg;
            end
            default: begin
                op_a = zr_reg;
                op_b = zr_reg;
            end
        endcase
    end

    etf_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // escape test: zr^2 + zi^2 against bailout in Q16.48, prod holds zi^2 here
    logic [PROD_W-1:0] norm_sum;
    logic [PROD_W-1:0] limit;

    assign norm_sum = $unsigned(rr_reg) + $unsigned(prod);
    assign limit    = {{(PROD_W-BAIL_W-24){1'b0}}, bailout_reg, 24'b0};

    assign status.escaped   = (norm_sum >= limit);
    assign status.iter_done = (n_reg >= max_iter_reg);

    // step: floor shifts are arithmetic shifts, prod holds zr*zi in update
    logic signed [SUM_W-1:0] re_sum;
    logic signed [SUM_W-1:0] im_sum;

    assign re_sum = SUM_W'($signed(diff_reg[PROD_W-1:24])) + SUM_W'(cr_reg);
    assign im_sum = SUM_W'($signed(prod[PROD_W-1:23])) + SUM_W'(ci_reg);

    // pixel coordinates for the incoming beat
    logic signed [Q_W-1:0] map_re;
    logic signed [Q_W-1:0] map_im;
    logic signed [Q_W-1:0] jc_re;
    logic signed [Q_W-1:0] jc_im;

    assign map_re = map_tbl[s_pixel_col];
    assign map_im = map_tbl[s_pixel_row];
    assign jc_re  = {{(Q_W-CJ_W){c_real_reg[CJ_W-1]}}, c_real_reg};
    assign jc_im  = {{(Q_W-CJ_W){c_imag_reg[CJ_W-1]}}, c_imag_reg};

    always_comb begin
        zr_next = zr_reg;
        zi_next = zi_reg;
        cr_next = cr_reg;
        ci_next = ci_reg;
        n_next  = n_reg;
        if (ctrl.load) begin
            n_next = '0;
            if (julia_mode_reg) begin
                // julia: z starts at the pixel, c is fixed
                zr_next = map_re;
                zi_next = map_im;
                cr_next = jc_re;
                ci_next = jc_im;
            end else begin
                // mandelbrot: z starts at zero, c is the pixel
                zr_next = '0;
                zi_next = '0;
                cr_next = map_re;
                ci_next = map_im;
            end
        end else if (ctrl.update) begin
            zr_next = sat32(re_sum);
            zi_next = sat32(im_sum);
            n_next  = n_reg + ITER_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        if (ctrl.cap_rr) begin
            rr_reg <= prod;
        end
        if (ctrl.cap_diff) begin
            diff_reg <= rr_reg - prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else begin
            n_reg <= n_next;
        end
    end

    // result beat comes straight from the z registers
    assign s_ready      = ctrl.in_ready;
    assign m_valid      = ctrl.out_valid;
    assign m_final_real = zr_reg;
    assign m_final_imag = zi_reg;

`ifndef NO_ASSERTIONS
    // input and result sides are never open at the same time
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready and m_valid both high");

    // the step counter never runs past the bound while a pixel is in flight
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (n_reg <= max_iter_reg))
        else $error("step counter beyond the step bound");

    // an accepted beat starts work, the block is busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("block not busy after accepting a beat");

    // z only changes on load or update, so a pending result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_final_real) && $stable(m_final_imag)))
        else $error("result changed while stalled");
`endif

endmodule
